// ===== rtl/otg_pkg.sv =====
// ----------------------------------------------------------------------------
// Over-temperature guard package
// Shared widths, register indexes and reset values of the guard.
// ----------------------------------------------------------------------------
package otg_pkg;

  localparam int unsigned SampleBits  = 10;
  localparam int unsigned TimerBits   = 16;
  localparam int unsigned CountBits   = 8;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = (SampleBits > TimerBits) ? SampleBits : TimerBits;

  typedef logic [SampleBits-1:0]  sample_t;
  typedef logic [TimerBits-1:0]   timer_t;
  typedef logic [CountBits-1:0]   count_t;
  typedef logic [CfgIdxBits-1:0]  cfg_idx_t;
  typedef logic [CfgDataBits-1:0] cfg_data_t;

  localparam cfg_idx_t RegEnable       = 3'd0;
  localparam cfg_idx_t RegDangerLevel  = 3'd1;
  localparam cfg_idx_t RegSafeLevel    = 3'd2;
  localparam cfg_idx_t RegConfirmCount = 3'd3;
  localparam cfg_idx_t RegWaitTicks    = 3'd4;
  localparam cfg_idx_t RegWindowTicks  = 3'd5;

  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  localparam count_t ConfirmReset = 8'd3;
  localparam timer_t WaitReset    = 16'd5000;
  localparam count_t WindowReset  = 8'd32;
  localparam timer_t TimerMax     = '1;
  localparam count_t CountMax     = '1;

  typedef struct packed {
    logic    error_active;
    logic    safe_flag;
    logic    window_open;
    sample_t reading;
    logic    error_raised;
    logic    error_cleared;
  } result_t;

endpackage

// ===== rtl/over_temperature_guard_core.sv =====
// ----------------------------------------------------------------------------
// Over-temperature guard core
// Periodic thermistor supervision with peak capture and hysteresis.
// ----------------------------------------------------------------------------
// Each word is a millisecond tick or an ADC sample and yields one result word.
// The update of the timer, peaks and error state is done in the cycle in which
// the word is accepted, and the result is held in a single output register, so
// one word is taken every cycle while that register is empty or being read.
// Configuration writes take effect at once and should be made while idle.
module over_temperature_guard_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  otg_pkg::cfg_idx_t         cfg_idx_i,
  input  otg_pkg::cfg_data_t        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  otg_pkg::sample_t          sample_i,
  input  logic                      load_ok_i,
  input  logic                      power_ok_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      error_active_o,
  output logic                      safe_flag_o,
  output logic                      window_open_o,
  output otg_pkg::sample_t          reading_o,
  output logic                      error_raised_o,
  output logic                      error_cleared_o
);

  logic               enable_q;
  otg_pkg::sample_t   danger_q;
  otg_pkg::sample_t   safe_lvl_q;
  otg_pkg::count_t    confirm_q;
  otg_pkg::timer_t    wait_q;
  otg_pkg::count_t    window_q;

  otg_pkg::timer_t    timer_q, timer_d;
  logic               sampling_q, sampling_d;
  otg_pkg::sample_t   peak1_q, peak1_d;
  otg_pkg::sample_t   peak2_q, peak2_d;
  otg_pkg::sample_t   latched_q, latched_d;
  otg_pkg::count_t    count_q, count_d;
  logic               error_q, error_d;
  logic               safe_q, safe_d;
  logic               raised, cleared;

  otg_pkg::result_t   res_q;
  logic               out_valid_q;
  logic               in_accept;

  otg_pkg::timer_t    timer_inc;
  otg_pkg::count_t    count_inc;
  logic               qualifies;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      danger_q   <= '0;
      safe_lvl_q <= '1;
      confirm_q  <= otg_pkg::ConfirmReset;
      wait_q     <= otg_pkg::WaitReset;
      window_q   <= otg_pkg::WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        otg_pkg::RegEnable:       enable_q   <= cfg_wdata_i[0];
        otg_pkg::RegDangerLevel:  danger_q   <= cfg_wdata_i[otg_pkg::SampleBits-1:0];
        otg_pkg::RegSafeLevel:    safe_lvl_q <= cfg_wdata_i[otg_pkg::SampleBits-1:0];
        otg_pkg::RegConfirmCount: confirm_q  <= cfg_wdata_i[otg_pkg::CountBits-1:0];
        otg_pkg::RegWaitTicks:    wait_q     <= cfg_wdata_i[otg_pkg::TimerBits-1:0];
        otg_pkg::RegWindowTicks:  window_q   <= cfg_wdata_i[otg_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign timer_inc = (timer_q == otg_pkg::TimerMax) ? timer_q : timer_q + 1'b1;
  assign count_inc = (count_q == otg_pkg::CountMax) ? count_q : count_q + 1'b1;
  assign qualifies = error_q ? (peak2_q >= safe_lvl_q) : (peak2_q <= danger_q);

  always_comb begin
    timer_d    = timer_q;
    sampling_d = sampling_q;
    peak1_d    = peak1_q;
    peak2_d    = peak2_q;
    latched_d  = latched_q;
    count_d    = count_q;
    error_d    = error_q;
    safe_d     = safe_q;
    raised     = 1'b0;
    cleared    = 1'b0;
    if (operation_i == otg_pkg::OpSample) begin
      if (sampling_q) begin
        if (peak1_q < sample_i) begin
          peak1_d = sample_i;
        end else if (peak2_q < sample_i) begin
          peak2_d = sample_i;
        end
      end
    end else if (enable_q) begin
      timer_d = timer_inc;
      if (!sampling_q) begin
        if (timer_inc >= wait_q) begin
          if (load_ok_i && power_ok_i) begin
            timer_d    = '0;
            sampling_d = 1'b1;
            safe_d     = 1'b0;
          end else begin
            timer_d = wait_q;
          end
        end
      end else if (timer_inc >= {{(otg_pkg::TimerBits-otg_pkg::CountBits){1'b0}}, window_q}) begin
        timer_d    = '0;
        sampling_d = 1'b0;
        latched_d  = peak2_q;
        peak1_d    = '0;
        peak2_d    = '0;
        if (qualifies) begin
          count_d = count_inc;
          if (count_inc >= confirm_q) begin
            count_d = '0;
            error_d = !error_q;
            raised  = !error_q;
            cleared = error_q;
          end
        end else begin
          count_d = '0;
        end
        if (!error_d) begin
          safe_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q    <= '0;
      sampling_q <= 1'b0;
      peak1_q    <= '0;
      peak2_q    <= '0;
      latched_q  <= '0;
      count_q    <= '0;
      error_q    <= 1'b0;
      safe_q     <= 1'b1;
    end else if (in_accept) begin
      timer_q    <= timer_d;
      sampling_q <= sampling_d;
      peak1_q    <= peak1_d;
      peak2_q    <= peak2_d;
      latched_q  <= latched_d;
      count_q    <= count_d;
      error_q    <= error_d;
      safe_q     <= safe_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q.error_active  <= error_d;
      res_q.safe_flag     <= safe_d;
      res_q.window_open   <= sampling_d;
      res_q.reading       <= latched_d;
      res_q.error_raised  <= raised;
      res_q.error_cleared <= cleared;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign error_active_o  = res_q.error_active;
  assign safe_flag_o     = res_q.safe_flag;
  assign window_open_o   = res_q.window_open;
  assign reading_o       = res_q.reading;
  assign error_raised_o  = res_q.error_raised;
  assign error_cleared_o = res_q.error_cleared;

  a_window_not_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sampling_q |-> !safe_q)
    else $error("safe state held while a window is open");

  a_error_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(error_q) && $stable(timer_q))
    else $error("guard state changed without an accepted word");

  a_pulses_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(raised && cleared))
    else $error("error raised and cleared by the same word");

  a_raise_sets_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && raised |=> error_q && out_valid_q && res_q.error_raised)
    else $error("error raise not reflected in state and result");

  a_peaks_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sampling_q |-> (peak1_q == '0) && (peak2_q == '0))
    else $error("peak registers not cleared outside a window");

endmodule
